[hdl/scd_pkg.sv]
`timescale 1ns / 1ps
package scd_pkg;

	localparam int DELAY_LENGTH    = 32768;
	localparam int AW              = $clog2(DELAY_LENGTH);
	localparam int SINE_TABLE_SIZE = 1024;
	localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
	localparam int QW              = SINE_BITS - 1;
	localparam int SINE_QTR        = SINE_TABLE_SIZE / 4;
	localparam int SINE_HALF       = SINE_TABLE_SIZE / 2;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic signed [17:0] LEAK_MUL  = 18'sd65529;
	localparam logic [30:0]        DIV50_MUL = 31'd1374389535;
	localparam int                 DIV50_SH  = 36;
	localparam logic [26:0]        DIV3_MUL  = 27'd89478486;
	localparam int                 DIV3_SH   = 28;

	localparam logic [23:0] PHASE_LEFT_RST  = 24'd3106892;
	localparam logic [23:0] PHASE_RIGHT_RST = 24'd8388608;

	localparam logic [1:0] CFG_LFO_STEP  = 2'd0;
	localparam logic [1:0] CFG_DEPTH     = 2'd1;
	localparam logic [1:0] CFG_CYCLE_END = 2'd2;

	localparam int SW = 5;
	localparam logic [SW-1:0] ST_CLEAR = 5'd0;
	localparam logic [SW-1:0] ST_IDLE  = 5'd1;
	localparam logic [SW-1:0] ST_AIR1  = 5'd2;
	localparam logic [SW-1:0] ST_AIR2  = 5'd3;
	localparam logic [SW-1:0] ST_AIR3  = 5'd4;
	localparam logic [SW-1:0] ST_AIR4  = 5'd5;
	localparam logic [SW-1:0] ST_AIR5  = 5'd6;
	localparam logic [SW-1:0] ST_AIR6  = 5'd7;
	localparam logic [SW-1:0] ST_AIR7  = 5'd8;
	localparam logic [SW-1:0] ST_WR    = 5'd9;
	localparam logic [SW-1:0] ST_OFS   = 5'd10;
	localparam logic [SW-1:0] ST_RD0   = 5'd11;
	localparam logic [SW-1:0] ST_RD1   = 5'd12;
	localparam logic [SW-1:0] ST_RD2   = 5'd13;
	localparam logic [SW-1:0] ST_RD3   = 5'd14;
	localparam logic [SW-1:0] ST_SUM1  = 5'd15;
	localparam logic [SW-1:0] ST_SUM2  = 5'd16;
	localparam logic [SW-1:0] ST_SUM3  = 5'd17;
	localparam logic [SW-1:0] ST_HOLD1 = 5'd18;
	localparam logic [SW-1:0] ST_HOLD2 = 5'd19;
	localparam logic [SW-1:0] ST_HOLD3 = 5'd20;
	localparam logic [SW-1:0] ST_OUT   = 5'd21;

	typedef struct packed {
		logic signed [23:0] in_left;
		logic signed [23:0] in_right;
	} in_t;

	typedef struct packed {
		logic signed [23:0] out_left;
		logic signed [23:0] out_right;
	} out_t;

	typedef struct packed {
		logic [SW-1:0] op;
		logic          load;
		logic          toggle;
		logic [AW-1:0] wp;
		logic          we;
		logic [AW-1:0] waddr;
		logic          wzero;
		logic [2:0]    ce;
		logic [1:0]    rsel;
	} cmd_t;

	typedef logic [SINE_QTR:0][15:0] sine_tab_t;

	// quarter wave of the LFO sine, Q1.15 magnitude, unclamped
	function automatic logic [15:0] sine_mag(input int q);
		longint unsigned x, x2, t, r, v;
		begin
			x  = (64'(4 * q) * HALF_PI_Q30) / SINE_TABLE_SIZE;
			x2 = (x * x) >> 30;
			t  = Q30_ONE - x2 / 110;
			t  = Q30_ONE - ((x2 * t) >> 30) / 72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 6;
			r  = (x * t) >> 30;
			v  = (r + 64'd16384) >> 15;
			return v[15:0];
		end
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		begin
			for (int i = 0; i <= SINE_QTR; i++) begin
				tab[i] = sine_mag(i);
			end
			return tab;
		end
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	function automatic logic [2:0] ce_clamp(input logic [2:0] v);
		begin
			if (v == 3'd0) return 3'd1;
			if (v > 3'd4) return 3'd4;
			return v;
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		begin
			if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		begin
			if (v > 64'sd8388607) return 24'sh7FFFFF;
			if (v < -64'sd8388608) return 24'sh800000;
			return v[23:0];
		end
	endfunction

endpackage

[hdl/scd_ram.sv]
`timescale 1ns / 1ps
module scd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/scd_ctrl.sv]
`timescale 1ns / 1ps
module scd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [23:0]       lfo_step,
	input  logic [2:0]        cycle_end,
	input  logic              out_free,
	output logic              load_out,
	output logic [23:0]       phase_left,
	output logic [23:0]       phase_right,
	output scd_pkg::cmd_t     cmd
);
	import scd_pkg::*;

	logic [SW-1:0] state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] wp_q;
	logic [1:0]    rp_q;
	logic          toggle_q;
	logic [23:0]   phl_q;
	logic [23:0]   phr_q;
	logic [2:0]    ce;
	logic [2:0]    cem1;
	logic [2:0]    rpc;
	logic [2:0]    rpn;
	logic          step;
	logic          accept;

	assign ce     = ce_clamp(cycle_end);
	assign cem1   = ce - 3'd1;
	assign rpc    = ({1'b0, rp_q} > cem1) ? cem1 : {1'b0, rp_q};
	assign rpn    = rpc + 3'd1;
	assign step   = (rpn == ce);
	assign accept = (state_q == ST_IDLE) && in_valid;

	assign in_stall    = (state_q != ST_IDLE);
	assign load_out    = (state_q == ST_OUT) && out_free;
	assign phase_left  = phl_q;
	assign phase_right = phr_q;

	always_comb begin
		cmd        = '0;
		cmd.op     = state_q;
		cmd.load   = accept;
		cmd.toggle = toggle_q;
		cmd.wp     = wp_q;
		cmd.ce     = ce;
		cmd.rsel   = rp_q;
		cmd.waddr  = wp_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.we    = 1'b1;
				cmd.wzero = 1'b1;
				cmd.waddr = clr_q;
			end
			ST_WR: begin
				cmd.we = 1'b1;
			end
			default: begin
				cmd.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			wp_q     <= '0;
			rp_q     <= '0;
			toggle_q <= 1'b0;
			phl_q    <= PHASE_LEFT_RST;
			phr_q    <= PHASE_RIGHT_RST;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DELAY_LENGTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (step) begin
							rp_q    <= '0;
							wp_q    <= wp_q - 1'b1;
							state_q <= ST_AIR1;
						end else begin
							rp_q    <= rpn[1:0];
							state_q <= ST_OUT;
						end
					end
				end
				ST_AIR1: begin
					toggle_q <= ~toggle_q;
					state_q  <= ST_AIR2;
				end
				ST_AIR2:  state_q <= ST_AIR3;
				ST_AIR3:  state_q <= ST_AIR4;
				ST_AIR4:  state_q <= ST_AIR5;
				ST_AIR5:  state_q <= ST_AIR6;
				ST_AIR6:  state_q <= ST_AIR7;
				ST_AIR7:  state_q <= ST_WR;
				ST_WR:    state_q <= ST_OFS;
				ST_OFS: begin
					// sine was taken in the write cycle, so advance now
					phl_q   <= phl_q + lfo_step;
					phr_q   <= phr_q + lfo_step;
					state_q <= ST_RD0;
				end
				ST_RD0:   state_q <= ST_RD1;
				ST_RD1:   state_q <= ST_RD2;
				ST_RD2:   state_q <= ST_RD3;
				ST_RD3:   state_q <= ST_SUM1;
				ST_SUM1:  state_q <= ST_SUM2;
				ST_SUM2:  state_q <= ST_SUM3;
				ST_SUM3:  state_q <= ST_HOLD1;
				ST_HOLD1: state_q <= ST_HOLD2;
				ST_HOLD2: state_q <= ST_HOLD3;
				ST_HOLD3: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[hdl/scd_lane.sv]
`timescale 1ns / 1ps
module scd_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  scd_pkg::cmd_t      cmd,
	input  logic signed [23:0] sample,
	input  logic [23:0]        phase,
	input  logic [21:0]        depth,
	output logic signed [23:0] result
);
	import scd_pkg::*;

	logic signed [23:0] x_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] even_q;
	logic signed [31:0] odd_q;
	logic signed [31:0] f_q;
	logic signed [33:0] v_q;
	logic signed [51:0] prod_q;
	logic signed [23:0] bst_q;
	logic [15:0]        s_q;
	logic [23:0]        off_q;
	logic signed [23:0] a_q;
	logic signed [23:0] b_q;
	logic signed [23:0] c_q;
	logic signed [33:0] pa_q;
	logic signed [33:0] pc_q;
	logic               dneg_q;
	logic [25:0]        dabs_q;
	logic [56:0]        dm_q;
	logic signed [25:0] ta_q;
	logic signed [25:0] tc_q;
	logic signed [23:0] y_q;
	logic [52:0]        prod3_q;
	logic               neg3_q;
	logic signed [23:0] h_q [5];

	logic signed [32:0] fd;
	logic [SINE_BITS-1:0] sidx;
	logic [QW-1:0]      shalf;
	logic [QW-1:0]      qidx;
	logic [15:0]        tval;
	logic signed [16:0] sine;
	logic [16:0]        sum17;
	logic [37:0]        mprod;
	logic [AW-1:0]      base;
	logic [AW-1:0]      raddr;
	logic [23:0]        rdata;
	logic [7:0]         frac;
	logic signed [9:0]  wa;
	logic signed [9:0]  wc;
	logic signed [25:0] dsum;
	logic [25:0]        q50;
	logic signed [26:0] qs;
	logic signed [26:0] sum27;
	logic signed [25:0] n3;
	logic signed [23:0] q3;

	function automatic logic signed [25:0] div256_trunc(input logic signed [33:0] p);
		logic signed [33:0] adj;
		begin
			adj = p + (p < 0 ? 34'sd255 : 34'sd0);
			return 26'(adj >>> 8);
		end
	endfunction

	function automatic logic signed [23:0] half_trunc(input logic signed [24:0] s);
		logic signed [24:0] adj;
		begin
			adj = s + (s < 0 ? 25'sd1 : 25'sd0);
			return 24'(adj >>> 1);
		end
	endfunction

	// fold the phase onto the quarter-wave table
	assign sidx  = phase[23 -: SINE_BITS];
	assign shalf = sidx[QW-1:0];
	assign qidx  = (shalf > QW'(SINE_QTR)) ? QW'(SINE_HALF - int'(shalf)) : shalf;
	assign tval  = SINE_TAB[qidx];
	assign sine  = sidx[SINE_BITS-1] ? -$signed({1'b0, tval})
	             : ((tval > 16'd32767) ? 17'sd32767 : $signed({1'b0, tval}));
	assign sum17 = 17'(sine) + 17'd32768;
	assign mprod = depth * s_q;

	assign fd    = 33'(prev_q) - 33'(x_q);
	assign base  = cmd.wp + AW'(off_q[23:8]);
	assign frac  = off_q[7:0];
	assign wa    = 10'sd256 - $signed({2'b0, frac});
	assign wc    = $signed({2'b0, frac});
	assign dsum  = 26'(a_q) - (26'(b_q) <<< 1) + 26'(c_q);
	assign q50   = 26'(dm_q >> DIV50_SH);
	assign qs    = dneg_q ? -$signed({1'b0, q50}) : $signed({1'b0, q50});
	assign sum27 = 27'(ta_q) + 27'(b_q) + 27'(tc_q) - qs;
	assign q3    = neg3_q ? -24'(prod3_q >> DIV3_SH) : 24'(prod3_q >> DIV3_SH);
	assign n3    = (cmd.op == ST_HOLD1) ? (26'(h_q[3]) <<< 1) + 26'(y_q)
	             : 26'(h_q[0]) + (26'(y_q) <<< 1);

	always_comb begin
		case (cmd.op)
			ST_RD1:  raddr = base + 1'b1;
			ST_RD2:  raddr = base + 2'd2;
			default: raddr = base;
		endcase
	end

	scd_ram #(
		.WIDTH(24),
		.DEPTH(DELAY_LENGTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (cmd.waddr),
		.wdata (cmd.wzero ? 24'd0 : bst_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign result = h_q[{1'b0, cmd.rsel}];

	// datapath payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= sample;
		end
		case (cmd.op)
			ST_AIR2: v_q <= 34'(odd_q) - 34'((33'(odd_q) - 33'(even_q)) >>> 8);
			ST_AIR3: prod_q <= v_q * LEAK_MUL;
			ST_AIR5: v_q <= 34'(even_q) - 34'((33'(even_q) - 33'(odd_q)) >>> 8);
			ST_AIR6: prod_q <= v_q * LEAK_MUL;
			ST_AIR7: bst_q <= sat24(64'(x_q) + 64'(f_q));
			ST_WR:   s_q <= sum17[15:0];
			ST_OFS:  off_q <= 24'(mprod >> 15);
			ST_RD1:  a_q <= $signed(rdata);
			ST_RD2:  b_q <= $signed(rdata);
			ST_RD3:  c_q <= $signed(rdata);
			ST_SUM1: begin
				pa_q   <= a_q * wa;
				pc_q   <= c_q * wc;
				dneg_q <= dsum[25];
				dabs_q <= dsum[25] ? 26'(-dsum) : 26'(dsum);
			end
			ST_SUM2: begin
				dm_q <= dabs_q * DIV50_MUL;
				ta_q <= div256_trunc(pa_q);
				tc_q <= div256_trunc(pc_q);
			end
			ST_SUM3: y_q <= sat24(64'(sum27 >>> 1));
			ST_HOLD1, ST_HOLD2: begin
				neg3_q  <= n3[25];
				prod3_q <= (n3[25] ? 26'(-n3) : 26'(n3)) * DIV3_MUL;
			end
			default: begin
			end
		endcase
	end

	// air accumulators and hold table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			even_q <= '0;
			odd_q  <= '0;
			f_q    <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= '0;
			end
		end else begin
			case (cmd.op)
				ST_AIR1: begin
					if (cmd.toggle) begin
						even_q <= sat32(64'(even_q) + 64'(fd));
						odd_q  <= sat32(64'(odd_q) - 64'(fd));
						f_q    <= sat32(64'(even_q) + 64'(fd));
					end else begin
						odd_q  <= sat32(64'(odd_q) + 64'(fd));
						even_q <= sat32(64'(even_q) - 64'(fd));
						f_q    <= sat32(64'(odd_q) + 64'(fd));
					end
				end
				ST_AIR4: odd_q <= sat32((64'(prod_q) + 64'sd32768) >>> 16);
				ST_AIR7: begin
					even_q <= sat32((64'(prod_q) + 64'sd32768) >>> 16);
					prev_q <= 32'(x_q);
				end
				ST_HOLD1: begin
					case (cmd.ce)
						3'd4: begin
							h_q[0] <= h_q[4];
							h_q[2] <= half_trunc(25'(h_q[4]) + 25'(y_q));
						end
						3'd3: h_q[0] <= h_q[3];
						3'd2: begin
							h_q[0] <= h_q[2];
							h_q[1] <= half_trunc(25'(h_q[2]) + 25'(y_q));
							h_q[2] <= y_q;
						end
						default: h_q[0] <= y_q;
					endcase
				end
				ST_HOLD2: begin
					case (cmd.ce)
						3'd4: begin
							h_q[1] <= half_trunc(25'(h_q[0]) + 25'(h_q[2]));
							h_q[3] <= half_trunc(25'(h_q[2]) + 25'(y_q));
							h_q[4] <= y_q;
						end
						3'd3: h_q[1] <= q3;
						default: begin
						end
					endcase
				end
				ST_HOLD3: begin
					if (cmd.ce == 3'd3) begin
						h_q[2] <= q3;
						h_q[3] <= y_q;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

[hdl/stereo_chorus_delay_top.sv]
`timescale 1ns / 1ps
// Item between chorus steps: the controller passes from idle to the output state and loads the
// result into the output register once it is free; no new item is taken before it is back in idle.
// Chorus step item: through the sequencer states (air boost, delay write, three serial taps
// on the single read port, filter and hold update), then the output state; no new item is taken until idle.
// Reset clears the delay lines by a pass over all 32768 entries, one entry a cycle; inputs stall
// throughout and configuration writes are taken as usual.
module stereo_chorus_delay_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  scd_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output scd_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_data
);
	import scd_pkg::*;

	logic [23:0] lfo_q;
	logic [21:0] depth_q;
	logic [2:0]  ce_q;
	logic        out_valid_q;
	out_t        out_q;
	logic        out_free;
	logic        load_out;
	logic [23:0] phase_left;
	logic [23:0] phase_right;
	cmd_t        cmd;
	logic signed [23:0] res_left;
	logic signed [23:0] res_right;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_q   <= '0;
			depth_q <= '0;
			ce_q    <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LFO_STEP:  lfo_q   <= cfg_data;
				CFG_DEPTH:     depth_q <= cfg_data[21:0];
				CFG_CYCLE_END: ce_q    <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	scd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.lfo_step    (lfo_q),
		.cycle_end   (ce_q),
		.out_free    (out_free),
		.load_out    (load_out),
		.phase_left  (phase_left),
		.phase_right (phase_right),
		.cmd         (cmd)
	);

	scd_lane u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (in_data.in_left),
		.phase  (phase_left),
		.depth  (depth_q),
		.result (res_left)
	);

	scd_lane u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (in_data.in_right),
		.phase  (phase_right),
		.depth  (depth_q),
		.result (res_right)
	);

	// hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.out_left  <= res_left;
			out_q.out_right <= res_right;
		end
	end
endmodule
